// ===== rtl/kvrp_pkg.sv =====
// Shared types, codes and constants of the key-value cache response parser.
package kvrp_pkg;

   localparam int unsigned HEADER_BYTES = 24;
   localparam int unsigned IDX_W        = 5;
   localparam int unsigned LEN_W        = 15;
   localparam int unsigned CSR_ADDR_W   = 2;
   localparam int unsigned CSR_DATA_W   = 15;

   localparam logic [14:0] MAX_BODY_RESET = 15'd16384;
   localparam logic [7:0]  MAGIC_RESET    = 8'd129;
   localparam logic [7:0]  GET_OP_RESET   = 8'd0;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_RESPONSE_MAGIC = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GET_OPCODE     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_BODY_BYTES = 2'd2;

   // Header byte positions that carry captured fields
   localparam logic [IDX_W-1:0] HDR_MAGIC      = 5'd0;
   localparam logic [IDX_W-1:0] HDR_OPCODE     = 5'd1;
   localparam logic [IDX_W-1:0] HDR_KEYLEN_HI  = 5'd2;
   localparam logic [IDX_W-1:0] HDR_KEYLEN_LO  = 5'd3;
   localparam logic [IDX_W-1:0] HDR_EXTRAS     = 5'd4;
   localparam logic [IDX_W-1:0] HDR_STATUS_HI  = 5'd6;
   localparam logic [IDX_W-1:0] HDR_STATUS_LO  = 5'd7;
   localparam logic [IDX_W-1:0] HDR_BODY_FIRST = 5'd8;
   localparam logic [IDX_W-1:0] HDR_BODY_LAST  = 5'd11;
   localparam logic [IDX_W-1:0] HDR_FINAL      = 5'(HEADER_BYTES - 1);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_EXTRAS = 2'd1,
      PH_VALUE  = 2'd2,
      PH_STUCK  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ERR_OK            = 3'd0,
      ERR_NONE_PENDING  = 3'd1,
      ERR_MAGIC         = 3'd2,
      ERR_OPCODE        = 3'd3,
      ERR_KEYLEN        = 3'd4,
      ERR_TOO_LARGE     = 3'd5,
      ERR_GET_NO_EXTRAS = 3'd6,
      ERR_TOO_SHORT     = 3'd7
   } err_type;

   // Captured header fields handed to the checker
   typedef struct packed {
      logic        saw_bad_magic;
      logic [7:0]  resp_opcode;
      logic [15:0] key_length;
      logic [7:0]  extras_length;
      logic [15:0] status_word;
      logic [31:0] body_length;
   } hdr_type;

   // Configuration seen by the checker
   typedef struct packed {
      logic [7:0]       get_opcode;
      logic [LEN_W-1:0] max_body_bytes;
   } chk_cfg_type;

endpackage

// ===== rtl/kvrp_hdr_check.sv =====
// Header validation: picks the first failing check of a completed header.
module kvrp_hdr_check (
   input  kvrp_pkg::hdr_type     hdr,
   input  kvrp_pkg::chk_cfg_type cfg,
   input  logic                  request_pending,
   input  logic [7:0]            expected_op,
   output kvrp_pkg::err_type     err
);
   import kvrp_pkg::*;

   logic [16:0] key_plus_extras;

   assign key_plus_extras = {1'b0, hdr.key_length} + {9'd0, hdr.extras_length};

   always_comb begin
      priority if (!request_pending) begin
         err = ERR_NONE_PENDING;
      end else if (hdr.saw_bad_magic) begin
         err = ERR_MAGIC;
      end else if (expected_op != hdr.resp_opcode) begin
         err = ERR_OPCODE;
      end else if (hdr.key_length != 16'd0) begin
         err = ERR_KEYLEN;
      end else if (hdr.body_length > {17'd0, cfg.max_body_bytes}) begin
         err = ERR_TOO_LARGE;
      end else if (hdr.resp_opcode == cfg.get_opcode && hdr.status_word == 16'd0
                   && hdr.extras_length == 8'd0) begin
         err = ERR_GET_NO_EXTRAS;
      end else if (hdr.body_length < {15'd0, key_plus_extras}) begin
         err = ERR_TOO_SHORT;
      end else begin
         err = ERR_OK;
      end
   end

endmodule

// ===== rtl/kv_cache_response_parser_top.sv =====
// Top level of the key-value cache response parser.
//
// Parses binary key-value cache responses from a received byte stream, one
// byte per input item. Each response is a 24-byte big-endian header, then
// extras that are dropped, then value bytes that are passed out one per result
// item together with the header status; the last value byte is marked with
// tlast. A response with an empty value gives a single completion item with
// tuser (has_byte) low and tlast high. When the 24th header byte arrives the
// header is checked (request pending, magic, opcode, key length zero, body
// size limit, get success carrying extras, body covering extras); the first
// failure yields one error item and the parser then ignores data bytes until
// a drop command (tuser high on the input), which also clears a parse in
// progress and gives no result. Throughput is one byte per clock while
// rsp_tready lets results drain: an item passes an input register, is
// parsed by the field capture, compare and counter logic, and lands in
// the result register. The result register lets the next byte be taken
// while a result waits; backpressure on rsp_tready stalls the input once
// both registers hold an item. The user must write configuration
// registers through the csr port only while the stream is idle; the block
// itself does not enforce this. Writes to an index past the last register
// are ignored.
module kv_cache_response_parser_top (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [kvrp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [kvrp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // data_byte, request_pending, expected_op
   input  logic                              req_tuser,  // cmd
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // value_byte, status, error, zero pad
   output logic                              rsp_tuser,  // has_byte
   output logic                              rsp_tlast   // last
);
   import kvrp_pkg::*;

   // configuration registers
   logic [7:0]       magic_ff;
   logic [7:0]       get_op_ff;
   logic [LEN_W-1:0] max_body_ff;

   // input register
   logic             in_valid_ff;
   logic             in_cmd_ff;
   logic [7:0]       in_byte_ff;
   logic             in_pending_ff;
   logic [7:0]       in_exp_op_ff;

   // parser state
   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   hdr_type          hdr_ff, hdr_in;
   logic [LEN_W-1:0] left_ff, left_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_has_ff, rsp_has_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [15:0]      rsp_status_ff, rsp_status_in;
   err_type          rsp_err_ff, rsp_err_in;

   logic             advance;
   logic             produce;
   err_type          chk_err;
   chk_cfg_type      chk_cfg;
   logic [LEN_W-1:0] value_len;

   // Parse the held item when the result register is free or draining.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign chk_cfg.get_opcode     = get_op_ff;
   assign chk_cfg.max_body_bytes = max_body_ff;

   kvrp_hdr_check u_check (
      .hdr             (hdr_ff),
      .cfg             (chk_cfg),
      .request_pending (in_pending_ff),
      .expected_op     (in_exp_op_ff),
      .err             (chk_err)
   );

   // Value length, modulo the counter width.
   assign value_len = hdr_ff.body_length[LEN_W-1:0] - hdr_ff.key_length[LEN_W-1:0]
                      - {7'd0, hdr_ff.extras_length};

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff    <= MAGIC_RESET;
         get_op_ff   <= GET_OP_RESET;
         max_body_ff <= MAX_BODY_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RESPONSE_MAGIC: magic_ff    <= csr_wdata[7:0];
            CSR_GET_OPCODE:     get_op_ff   <= csr_wdata[7:0];
            CSR_MAX_BODY_BYTES: max_body_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: hold the item until the parser takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff     <= req_tuser;
         in_byte_ff    <= req_tdata[7:0];
         in_pending_ff <= req_tdata[8];
         in_exp_op_ff  <= req_tdata[16:9];
      end
   end

   // Parser: next state and result for the held item.
   always_comb begin
      phase_in      = phase_ff;
      hdr_idx_in    = hdr_idx_ff;
      hdr_in        = hdr_ff;
      left_in       = left_ff;
      produce       = 1'b0;
      rsp_has_in    = 1'b0;
      rsp_byte_in   = 8'd0;
      rsp_last_in   = 1'b0;
      rsp_status_in = hdr_ff.status_word;
      rsp_err_in    = ERR_OK;

      if (advance) begin
         if (in_cmd_ff) begin
            // drop: restart on a fresh header
            phase_in   = PH_HEADER;
            hdr_idx_in = '0;
            left_in    = '0;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  priority if (hdr_idx_ff == HDR_MAGIC) begin
                     hdr_in.saw_bad_magic = (in_byte_ff != magic_ff);
                  end else if (hdr_idx_ff == HDR_OPCODE) begin
                     hdr_in.resp_opcode = in_byte_ff;
                  end else if (hdr_idx_ff == HDR_KEYLEN_HI
                               || hdr_idx_ff == HDR_KEYLEN_LO) begin
                     hdr_in.key_length = {hdr_ff.key_length[7:0], in_byte_ff};
                  end else if (hdr_idx_ff == HDR_EXTRAS) begin
                     hdr_in.extras_length = in_byte_ff;
                  end else if (hdr_idx_ff == HDR_STATUS_HI
                               || hdr_idx_ff == HDR_STATUS_LO) begin
                     hdr_in.status_word = {hdr_ff.status_word[7:0], in_byte_ff};
                  end else if (hdr_idx_ff >= HDR_BODY_FIRST
                               && hdr_idx_ff <= HDR_BODY_LAST) begin
                     hdr_in.body_length = {hdr_ff.body_length[23:0], in_byte_ff};
                  end else begin
                  end

                  if (hdr_idx_ff != HDR_FINAL) begin
                     hdr_idx_in = hdr_idx_ff + 5'd1;
                  end else begin
                     hdr_idx_in = '0;
                     priority if (chk_err != ERR_OK) begin
                        phase_in   = PH_STUCK;
                        produce    = 1'b1;
                        rsp_err_in = chk_err;
                     end else if (hdr_ff.extras_length != 8'd0) begin
                        phase_in = PH_EXTRAS;
                        left_in  = {7'd0, hdr_ff.extras_length};
                     end else if (value_len == '0) begin
                        produce     = 1'b1;
                        rsp_last_in = 1'b1;
                     end else begin
                        phase_in = PH_VALUE;
                        left_in  = value_len;
                     end
                  end
               end
               PH_EXTRAS: begin
                  priority if (left_ff > 15'd1) begin
                     left_in = left_ff - 15'd1;
                  end else if (value_len == '0) begin
                     // empty value: finish after the extras
                     phase_in    = PH_HEADER;
                     left_in     = '0;
                     produce     = 1'b1;
                     rsp_last_in = 1'b1;
                  end else begin
                     phase_in = PH_VALUE;
                     left_in  = value_len;
                  end
               end
               PH_VALUE: begin
                  produce     = 1'b1;
                  rsp_has_in  = 1'b1;
                  rsp_byte_in = in_byte_ff;
                  if (left_ff > 15'd1) begin
                     left_in = left_ff - 15'd1;
                  end else begin
                     phase_in    = PH_HEADER;
                     left_in     = '0;
                     rsp_last_in = 1'b1;
                  end
               end
               PH_STUCK: begin
                  // drop data bytes until the connection is dropped
               end
               default: ;
            endcase
         end
      end

      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_idx_ff   <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      if (produce) begin
         rsp_has_ff    <= rsp_has_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
         rsp_err_ff    <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_err_ff, rsp_status_ff, rsp_byte_ff};

   // An error item never carries a byte and never completes a response.
   a_err_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff != ERR_OK |-> !rsp_has_ff && !rsp_last_ff)
      else $error("error item carries a byte or last");

   // An item without a byte is either an error or an empty-value completion.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_ff && rsp_err_ff == ERR_OK |-> rsp_last_ff)
      else $error("byte-less ok item without last");

   // Entering the stuck phase always loads an error item.
   a_stuck_with_error: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_STUCK ##1 phase_ff == PH_STUCK |-> rsp_valid_ff && rsp_err_ff != ERR_OK)
      else $error("stuck without error item");

   // The header counter rests at zero outside the header phase.
   a_idx_rest: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HEADER |-> hdr_idx_ff == '0)
      else $error("header index not cleared");

   // The header counter never runs past the header.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      hdr_idx_ff <= HDR_FINAL)
      else $error("header index out of range");

endmodule
